@@ sv/jbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// jbsm_pkg
// Shared types, opcodes and decode helpers for the bytecode stack machine.
// ----------------------------------------------------------------------------
`default_nettype none

package jbsm_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int LOCAL_COUNT     = 4;

	localparam logic [7:0] OP_BIPUSH  = 8'h10;
	localparam logic [7:0] OP_SIPUSH  = 8'h11;
	localparam logic [7:0] OP_ILOAD0  = 8'h1a;
	localparam logic [7:0] OP_ISTORE0 = 8'h3b;
	localparam logic [7:0] OP_IADD    = 8'h60;
	localparam logic [7:0] OP_ISUB    = 8'h64;
	localparam logic [7:0] OP_IMUL    = 8'h68;
	localparam logic [7:0] OP_IDIV    = 8'h6c;
	localparam logic [7:0] OP_IRETURN = 8'hac;
	localparam logic [7:0] OP_RETURN  = 8'hb1;

	localparam logic [1:0] END_VOID  = 2'd0;
	localparam logic [1:0] END_INT   = 2'd1;
	localparam logic [1:0] END_CODE  = 2'd2;
	localparam logic [1:0] END_FAULT = 2'd3;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] return_value;
		logic [1:0]         end_kind;
	} out_item_t;

	typedef enum logic [3:0] {
		CLS_NOP, CLS_CONST, CLS_BIPUSH, CLS_SIPUSH, CLS_ILOAD,
		CLS_STORE, CLS_ARITH, CLS_RETURN, CLS_IRETURN
	} op_cls_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_RD_B, ST_RD_A, ST_ALU, ST_DIV, ST_WB, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_CONST, SRC_LOCAL, SRC_OPND, SRC_ALU
	} push_src_t;

	// controller -> datapath
	typedef struct packed {
		logic       latch;
		logic       opnd_start;
		logic       opnd_hi;
		logic       push;
		push_src_t  push_src;
		logic       rd;
		logic       rd_off;
		logic       cap_b;
		logic       cap_a;
		logic       store_local;
		logic       alu_go;
		logic       wb;
		logic       set_kind;
		logic [1:0] kind;
		logic       emit;
		logic       fresh;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_cls_t cls;
		logic    is_div;
		logic    skip;
		logic    pend;
		logic    pend_hi;
		logic    last;
		logic    full;
		logic    ge1;
		logic    ge2;
		logic    div_busy;
		logic    out_busy;
	} sts_t;

	function automatic op_cls_t classify(input logic [7:0] op);
		op_cls_t c;
		c = CLS_NOP;
		if (op >= 8'h01 && op <= 8'h0f) c = CLS_CONST;
		else if (op == OP_BIPUSH) c = CLS_BIPUSH;
		else if (op == OP_SIPUSH) c = CLS_SIPUSH;
		else if (op >= OP_ILOAD0 && op < OP_ILOAD0 + 8'(LOCAL_COUNT)) c = CLS_ILOAD;
		else if (op >= OP_ISTORE0 && op < OP_ISTORE0 + 8'(LOCAL_COUNT)) c = CLS_STORE;
		else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV)
			c = CLS_ARITH;
		else if (op == OP_RETURN) c = CLS_RETURN;
		else if (op == OP_IRETURN) c = CLS_IRETURN;
		return c;
	endfunction

	// raw slot patterns of the constant-push opcodes
	function automatic logic [63:0] const_val(input logic [7:0] op);
		logic [63:0] v;
		v = 64'd0;
		if (op >= 8'h02 && op <= 8'h08) begin
			v = {{56{op == 8'h02}}, op - 8'd3};
		end else begin
			case (op)
				8'h0a: v = 64'd1;
				8'h0c: v = 64'h0000_0000_3F80_0000;
				8'h0d: v = 64'h0000_0000_4000_0000;
				8'h0f: v = 64'h3FF0_0000_0000_0000;
				default: v = 64'd0;
			endcase
		end
		return v;
	endfunction

endpackage

`default_nettype wire

@@ sv/jbsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// jbsm_ctrl
// Sequencer: walks one code byte through decode, stack reads, ALU and result.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire jbsm_pkg::sts_t sts,
	output jbsm_pkg::cmd_t      cmd
);

	jbsm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= jbsm_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		logic done;     // item finished with no ending of its own
		logic fault;
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != jbsm_pkg::ST_IDLE);
		done     = 1'b0;
		fault    = 1'b0;
		unique case (state_q)
			jbsm_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = jbsm_pkg::ST_DECODE;
				end
			end
			jbsm_pkg::ST_DECODE: begin
				if (sts.skip) begin
					cmd.fresh = sts.last;
					state_d   = jbsm_pkg::ST_IDLE;
				end else if (sts.pend) begin
					if (sts.pend_hi) begin
						cmd.opnd_hi = 1'b1;
						done        = 1'b1;
					end else if (sts.full) begin
						fault = 1'b1;
					end else begin
						cmd.push     = 1'b1;
						cmd.push_src = jbsm_pkg::SRC_OPND;
						done         = 1'b1;
					end
				end else begin
					unique case (sts.cls)
						jbsm_pkg::CLS_BIPUSH, jbsm_pkg::CLS_SIPUSH: begin
							cmd.opnd_start = 1'b1;
							done           = 1'b1;
						end
						jbsm_pkg::CLS_CONST, jbsm_pkg::CLS_ILOAD: begin
							if (sts.full) begin
								fault = 1'b1;
							end else begin
								cmd.push     = 1'b1;
								cmd.push_src = (sts.cls == jbsm_pkg::CLS_ILOAD) ?
									jbsm_pkg::SRC_LOCAL : jbsm_pkg::SRC_CONST;
								done         = 1'b1;
							end
						end
						jbsm_pkg::CLS_STORE, jbsm_pkg::CLS_IRETURN: begin
							if (!sts.ge1) begin
								fault = 1'b1;
							end else begin
								cmd.rd  = 1'b1;
								state_d = jbsm_pkg::ST_RD_B;
							end
						end
						jbsm_pkg::CLS_ARITH: begin
							if (!sts.ge2) begin
								fault = 1'b1;
							end else begin
								cmd.rd  = 1'b1;
								state_d = jbsm_pkg::ST_RD_B;
							end
						end
						jbsm_pkg::CLS_RETURN: begin
							cmd.set_kind = 1'b1;
							cmd.kind     = jbsm_pkg::END_VOID;
							state_d      = jbsm_pkg::ST_EMIT;
						end
						default: done = 1'b1;
					endcase
				end
			end
			jbsm_pkg::ST_RD_B: begin
				cmd.cap_b = 1'b1;
				if (sts.cls == jbsm_pkg::CLS_ARITH) begin
					cmd.rd     = 1'b1;
					cmd.rd_off = 1'b1;
					state_d    = jbsm_pkg::ST_RD_A;
				end else if (sts.cls == jbsm_pkg::CLS_STORE) begin
					cmd.store_local = 1'b1;
					done            = 1'b1;
				end else begin
					cmd.set_kind = 1'b1;
					cmd.kind     = jbsm_pkg::END_INT;
					state_d      = jbsm_pkg::ST_EMIT;
				end
			end
			jbsm_pkg::ST_RD_A: begin
				cmd.cap_a = 1'b1;
				state_d   = jbsm_pkg::ST_ALU;
			end
			jbsm_pkg::ST_ALU: begin
				cmd.alu_go = 1'b1;
				state_d    = sts.is_div ? jbsm_pkg::ST_DIV : jbsm_pkg::ST_WB;
			end
			jbsm_pkg::ST_DIV: begin
				if (!sts.div_busy) state_d = jbsm_pkg::ST_WB;
			end
			jbsm_pkg::ST_WB: begin
				cmd.wb = 1'b1;
				done   = 1'b1;
			end
			jbsm_pkg::ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit  = 1'b1;
					cmd.fresh = 1'b1;
					state_d   = jbsm_pkg::ST_IDLE;
				end
			end
			default: state_d = jbsm_pkg::ST_IDLE;
		endcase

		if (fault) begin
			cmd.set_kind = 1'b1;
			cmd.kind     = jbsm_pkg::END_FAULT;
			state_d      = jbsm_pkg::ST_EMIT;
		end else if (done) begin
			if (sts.last) begin
				cmd.set_kind = 1'b1;
				cmd.kind     = jbsm_pkg::END_CODE;
				state_d      = jbsm_pkg::ST_EMIT;
			end else begin
				state_d = jbsm_pkg::ST_IDLE;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/jbsm_dpath.sv @@
// ----------------------------------------------------------------------------
// jbsm_dpath
// Frame storage, operand assembly, ALU with serial divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jbsm_dpath #(
	parameter int STACK_DEPTH = jbsm_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jbsm_pkg::in_item_t  in_item,
	input  wire jbsm_pkg::cmd_t      cmd,
	output jbsm_pkg::sts_t           sts,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output jbsm_pkg::out_item_t      out_item
);

	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int LW  = $clog2(jbsm_pkg::LOCAL_COUNT);

	logic [7:0]     byte_q;
	logic           last_q;
	logic [SPW-1:0] sp_q;
	logic [63:0]    stk [STACK_DEPTH];
	logic [63:0]    rd_q;
	logic [31:0]    loc_q [jbsm_pkg::LOCAL_COUNT];
	logic [7:0]     pend_op_q;
	logic [1:0]     left_q;
	logic [7:0]     high_q;
	logic           skip_q;
	logic [31:0]    a_q, b_q, res_q;
	logic [1:0]     kind_q;
	logic [31:0]    rv_q;
	logic           out_valid_q;
	jbsm_pkg::out_item_t out_q;

	// divider
	logic           div_busy_q, div_neg_q, div_zero_q;
	logic [5:0]     div_cnt_q;
	logic [31:0]    div_quo_q, div_rem_q, div_den_q;

	jbsm_pkg::op_cls_t cls;
	logic [LW-1:0]  loc_idx;
	logic [SPW-1:0] rd_pt, wb_pt;
	logic [63:0]    push_val;
	logic [31:0]    opnd_val;
	logic [63:0]    prod;
	logic [32:0]    div_try;

	assign cls     = jbsm_pkg::classify(byte_q);
	assign loc_idx = (cls == jbsm_pkg::CLS_ILOAD) ? LW'(byte_q - jbsm_pkg::OP_ILOAD0) :
	                                                LW'(byte_q - jbsm_pkg::OP_ISTORE0);
	assign rd_pt   = sp_q - SPW'(1) - SPW'(cmd.rd_off);
	assign wb_pt   = sp_q - SPW'(2);
	assign prod    = a_q * b_q;
	assign div_try = {div_rem_q, div_quo_q[31]} - {1'b0, div_den_q};

	always_comb begin
		if (pend_op_q == jbsm_pkg::OP_SIPUSH) opnd_val = {{16{high_q[7]}}, high_q, byte_q};
		else                                  opnd_val = {{24{byte_q[7]}}, byte_q};
		case (cmd.push_src)
			jbsm_pkg::SRC_CONST: push_val = jbsm_pkg::const_val(byte_q);
			jbsm_pkg::SRC_LOCAL: push_val = {{32{loc_q[loc_idx][31]}}, loc_q[loc_idx]};
			jbsm_pkg::SRC_OPND:  push_val = {{32{opnd_val[31]}}, opnd_val};
			default:             push_val = {{32{res_q[31]}}, res_q};
		endcase
	end

	// operand stack memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.push)    stk[sp_q[AW-1:0]]  <= push_val;
		else if (cmd.wb) stk[wb_pt[AW-1:0]] <= {{32{res_q[31]}}, res_q};
		if (cmd.rd)      rd_q <= stk[rd_pt[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= in_item.code_byte;
			last_q <= in_item.last_byte;
		end
		if (cmd.cap_b) b_q <= rd_q[31:0];
		if (cmd.cap_a) a_q <= rd_q[31:0];
		if (cmd.set_kind) begin
			kind_q <= cmd.kind;
			rv_q   <= (cmd.kind == jbsm_pkg::END_INT) ? rd_q[31:0] : 32'd0;
		end
		if (cmd.emit) begin
			out_q.return_value <= rv_q;
			out_q.end_kind     <= kind_q;
		end
		if (cmd.alu_go) begin
			if (byte_q == jbsm_pkg::OP_IADD)      res_q <= a_q + b_q;
			else if (byte_q == jbsm_pkg::OP_ISUB) res_q <= a_q - b_q;
			else if (byte_q == jbsm_pkg::OP_IMUL) res_q <= prod[31:0];
			div_quo_q  <= a_q[31] ? (32'd0 - a_q) : a_q;
			div_den_q  <= b_q[31] ? (32'd0 - b_q) : b_q;
			div_rem_q  <= 32'd0;
			div_neg_q  <= a_q[31] ^ b_q[31];
			div_zero_q <= (b_q == 32'd0);
		end else if (div_busy_q) begin
			// one restoring step per cycle
			if (!div_try[32]) begin
				div_rem_q <= div_try[31:0];
				div_quo_q <= {div_quo_q[30:0], 1'b1};
			end else begin
				div_rem_q <= {div_rem_q[30:0], div_quo_q[31]};
				div_quo_q <= {div_quo_q[30:0], 1'b0};
			end
		end else if (div_cnt_q == 6'd0 && !div_busy_q && cmd.wb == 1'b0
		             && byte_q == jbsm_pkg::OP_IDIV && !cmd.latch) begin
			res_q <= div_zero_q ? 32'd0 : (div_neg_q ? 32'd0 - div_quo_q : div_quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= 6'd0;
		end else if (cmd.alu_go && byte_q == jbsm_pkg::OP_IDIV) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 6'd32;
		end else if (div_busy_q) begin
			div_cnt_q  <= div_cnt_q - 6'd1;
			div_busy_q <= (div_cnt_q != 6'd1);
		end
	end

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			pend_op_q   <= 8'd0;
			left_q      <= 2'd0;
			high_q      <= 8'd0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < jbsm_pkg::LOCAL_COUNT; i++) loc_q[i] <= 32'd0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cmd.emit) out_valid_q <= 1'b1;
			if (cmd.fresh) begin
				sp_q      <= '0;
				pend_op_q <= 8'd0;
				left_q    <= 2'd0;
				high_q    <= 8'd0;
				skip_q    <= !last_q && cmd.emit;
				for (int i = 0; i < jbsm_pkg::LOCAL_COUNT; i++) loc_q[i] <= 32'd0;
			end else begin
				if (cmd.opnd_start) begin
					pend_op_q <= byte_q;
					left_q    <= (cls == jbsm_pkg::CLS_SIPUSH) ? 2'd2 : 2'd1;
				end
				if (cmd.opnd_hi) begin
					high_q <= byte_q;
					left_q <= 2'd1;
				end
				if (cmd.push) begin
					sp_q <= sp_q + SPW'(1);
					if (cmd.push_src == jbsm_pkg::SRC_OPND) begin
						pend_op_q <= 8'd0;
						left_q    <= 2'd0;
						high_q    <= 8'd0;
					end
				end
				if (cmd.store_local) begin
					loc_q[loc_idx] <= rd_q[31:0];
					sp_q           <= sp_q - SPW'(1);
				end
				if (cmd.wb) sp_q <= sp_q - SPW'(1);
			end
		end
	end

	always_comb begin
		sts.cls      = cls;
		sts.is_div   = (byte_q == jbsm_pkg::OP_IDIV);
		sts.skip     = skip_q;
		sts.pend     = (left_q != 2'd0);
		sts.pend_hi  = (pend_op_q == jbsm_pkg::OP_SIPUSH) && (left_q == 2'd2);
		sts.last     = last_q;
		sts.full     = (sp_q == SPW'(STACK_DEPTH));
		sts.ge1      = (sp_q >= SPW'(1));
		sts.ge2      = (sp_q >= SPW'(2));
		sts.div_busy = div_busy_q;
		sts.out_busy = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

@@ sv/java_bytecode_stack_machine.sv @@
// ----------------------------------------------------------------------------
// java_bytecode_stack_machine
// Executes a Java bytecode subset one code byte per item on a fresh frame per
// method and reports how each method ended.
// ----------------------------------------------------------------------------
//  channel | signals                     | item
//  --------+-----------------------------+----------------------------------
//  in      | in_valid, in_stall, in_item | code_byte, last_byte
//  out     | out_valid, out_stall, out_item | return_value, end_kind
//
// A byte is taken in the idle state and decoded the next cycle; istore/ireturn
//   and iadd/isub/imul take longer because of the single read port of the
//   operand stack, and idiv because of the one-bit-per-cycle divider.
// A byte that ends a method then passes through the emit state, which loads
//   the result register when the output is not stalled.
// Reset clears stack pointer, locals, operand state and the result valid flag.
// A stalled result holds; the block keeps taking bytes until a second ending
//   has to wait for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module java_bytecode_stack_machine #(
	parameter int STACK_DEPTH = jbsm_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire jbsm_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output jbsm_pkg::out_item_t      out_item
);

	jbsm_pkg::cmd_t cmd;
	jbsm_pkg::sts_t sts;

	// sequencer
	jbsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// frame storage, ALU and result register
	jbsm_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

@@ test/java_bytecode_stack_machine_tb.sv @@
// ----------------------------------------------------------------------------
// java_bytecode_stack_machine_tb
// Drives bytecode methods into the stack machine and checks every method
// ending against a behavioral interpreter held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module java_bytecode_stack_machine_tb;

	localparam int DEPTH     = jbsm_pkg::STACK_DEPTH_DEF;
	localparam int NLOC      = jbsm_pkg::LOCAL_COUNT;
	localparam int MAX_CYC   = 2000000;
	localparam int TAIL_CYC  = 200;
	localparam int N_RANDOM  = 800;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	jbsm_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	jbsm_pkg::out_item_t out_item;

	java_bytecode_stack_machine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// interpreter state
	logic [63:0] opstack [DEPTH];
	int          sp;
	logic [31:0] locals [NLOC];
	logic [7:0]  pend_op;
	int          pend_left;
	logic [7:0]  pend_hi;
	bit          skipping;

	jbsm_pkg::out_item_t endings_q [$];
	int        errors;
	int        n_checked;
	int        n_faults;
	int        n_iret;
	int        cycles;
	bit        hold_off;   // long receiver stall requested
	int        hold_len;

	function automatic void fresh_frame();
		for (int i = 0; i < DEPTH; i++) opstack[i] = '0;
		for (int i = 0; i < NLOC; i++) locals[i] = '0;
		sp = 0;
		pend_op = '0;
		pend_left = 0;
		pend_hi = '0;
		skipping = 1'b0;
	endfunction

	function automatic logic [63:0] sx(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic bit push(input logic [63:0] v);
		if (sp >= DEPTH) return 1'b0;
		opstack[sp] = v;
		sp++;
		return 1'b1;
	endfunction

	function automatic logic [31:0] pop();
		sp--;
		return opstack[sp][31:0];
	endfunction

	function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		if (b == 0) return '0;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	// one opcode; returns -1 to continue, else ending kind
	function automatic int run_op(input logic [7:0] op, output logic [31:0] rv);
		logic [31:0] a, b, r;
		rv = '0;
		if (op >= 8'h01 && op <= 8'h0f) begin
			case (op)
				8'h0a:   r = 32'd1;
				default: r = '0;
			endcase
			if (op >= 8'h02 && op <= 8'h08)
				return push(sx(32'(op) - 32'd3)) ? -1 : int'(jbsm_pkg::END_FAULT);
			if (op == 8'h0c) return push(64'h3F80_0000) ? -1 : int'(jbsm_pkg::END_FAULT);
			if (op == 8'h0d) return push(64'h4000_0000) ? -1 : int'(jbsm_pkg::END_FAULT);
			if (op == 8'h0f)
				return push(64'h3FF0_0000_0000_0000) ? -1 : int'(jbsm_pkg::END_FAULT);
			return push({32'd0, r}) ? -1 : int'(jbsm_pkg::END_FAULT);
		end
		if (op >= jbsm_pkg::OP_ILOAD0 && op < jbsm_pkg::OP_ILOAD0 + NLOC)
			return push(sx(locals[op - jbsm_pkg::OP_ILOAD0])) ? -1 :
				int'(jbsm_pkg::END_FAULT);
		if (op >= jbsm_pkg::OP_ISTORE0 && op < jbsm_pkg::OP_ISTORE0 + NLOC) begin
			if (sp < 1) return int'(jbsm_pkg::END_FAULT);
			locals[op - jbsm_pkg::OP_ISTORE0] = pop();
			return -1;
		end
		if (op == jbsm_pkg::OP_IADD || op == jbsm_pkg::OP_ISUB ||
		    op == jbsm_pkg::OP_IMUL || op == jbsm_pkg::OP_IDIV) begin
			if (sp < 2) return int'(jbsm_pkg::END_FAULT);
			b = pop();
			a = pop();
			if (op == jbsm_pkg::OP_IADD) r = a + b;
			else if (op == jbsm_pkg::OP_ISUB) r = a - b;
			else if (op == jbsm_pkg::OP_IMUL) r = a * b;
			else r = sdiv(a, b);
			void'(push(sx(r)));
			return -1;
		end
		if (op == jbsm_pkg::OP_RETURN) return int'(jbsm_pkg::END_VOID);
		if (op == jbsm_pkg::OP_IRETURN) begin
			if (sp < 1) return int'(jbsm_pkg::END_FAULT);
			rv = pop();
			return int'(jbsm_pkg::END_INT);
		end
		return -1;
	endfunction

	// advance the interpreter by one code byte, queue any ending
	function automatic void execute_byte(input jbsm_pkg::in_item_t it);
		logic [31:0]         rv, v;
		int                  kind;
		jbsm_pkg::out_item_t e;
		rv = '0;
		kind = -1;
		if (skipping) begin
			if (it.last_byte) fresh_frame();
			return;
		end
		if (pend_left != 0) begin
			if (pend_op == jbsm_pkg::OP_SIPUSH && pend_left == 2) begin
				pend_hi = it.code_byte;
				pend_left = 1;
			end else begin
				if (pend_op == jbsm_pkg::OP_SIPUSH) v = {{16{pend_hi[7]}}, pend_hi, it.code_byte};
				else v = {{24{it.code_byte[7]}}, it.code_byte};
				pend_left = 0;
				pend_op = '0;
				pend_hi = '0;
				if (!push(sx(v))) kind = int'(jbsm_pkg::END_FAULT);
			end
		end else if (it.code_byte == jbsm_pkg::OP_BIPUSH) begin
			pend_op = it.code_byte;
			pend_left = 1;
		end else if (it.code_byte == jbsm_pkg::OP_SIPUSH) begin
			pend_op = it.code_byte;
			pend_left = 2;
		end else begin
			kind = run_op(it.code_byte, rv);
		end
		if (kind < 0) begin
			if (!it.last_byte) return;
			kind = int'(jbsm_pkg::END_CODE);
		end
		if (kind != int'(jbsm_pkg::END_INT)) rv = '0;
		e.return_value = rv;
		e.end_kind = 2'(kind);
		endings_q.push_back(e);
		fresh_frame();
		if (!it.last_byte) skipping = 1'b1;
	endfunction

	// ---------------- sender ----------------
	// entered and left at a falling edge; valid drops only when a gap follows
	task automatic send_byte(input logic [7:0] b, input bit last);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item.code_byte <= b;
		in_item.last_byte <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		execute_byte('{code_byte: b, last_byte: last});
		@(negedge clk);
	endtask

	// method of n well-formed-ish random bytes
	task automatic send_method(input int n);
		logic [7:0] b;
		int         r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25) b = 8'($urandom_range(1, 15));
			else if (r < 35) b = jbsm_pkg::OP_BIPUSH;
			else if (r < 42) b = jbsm_pkg::OP_SIPUSH;
			else if (r < 52) b = jbsm_pkg::OP_ILOAD0 + 8'($urandom_range(0, 3));
			else if (r < 62) b = jbsm_pkg::OP_ISTORE0 + 8'($urandom_range(0, 3));
			else if (r < 82) begin
				case ($urandom_range(0, 3))
					0: b = jbsm_pkg::OP_IADD;
					1: b = jbsm_pkg::OP_ISUB;
					2: b = jbsm_pkg::OP_IMUL;
					default: b = jbsm_pkg::OP_IDIV;
				endcase
			end else if (r < 86) b = jbsm_pkg::OP_IRETURN;
			else if (r < 88) b = jbsm_pkg::OP_RETURN;
			else b = 8'($urandom);
			send_byte(b, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (endings_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYC) @(negedge clk);
	endtask

	// directed rows: byte, last flag, and a typed-in ending where obvious
	typedef struct {
		logic [7:0] b;
		bit         last;
		bit         has_exp;
		logic [31:0] rv;
		logic [1:0] kind;
	} row_t;

	row_t dir_tab [] = '{
		'{8'h00, 1'b1, 1'b1, 32'd0, jbsm_pkg::END_CODE},   // nop as whole method
		'{jbsm_pkg::OP_RETURN, 1'b1, 1'b1, 32'd0, jbsm_pkg::END_VOID},
		'{jbsm_pkg::OP_IRETURN, 1'b1, 1'b1, 32'd0, jbsm_pkg::END_FAULT},  // underflow
		'{jbsm_pkg::OP_IADD, 1'b1, 1'b1, 32'd0, jbsm_pkg::END_FAULT},
		'{jbsm_pkg::OP_BIPUSH, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{8'h80, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_IRETURN, 1'b1, 1'b1, 32'hFFFF_FF80, jbsm_pkg::END_INT}, // -128
		'{jbsm_pkg::OP_SIPUSH, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{8'h7f, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{8'hff, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_IRETURN, 1'b1, 1'b1, 32'h0000_7FFF, jbsm_pkg::END_INT},
		'{jbsm_pkg::OP_SIPUSH, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{8'h80, 1'b1, 1'b1, 32'd0, jbsm_pkg::END_CODE},   // truncated operand
		'{8'h02, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},   // push -1
		'{8'h02, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_IDIV, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_IRETURN, 1'b1, 1'b1, 32'd1, jbsm_pkg::END_INT},
		'{8'h03, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_IDIV, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},   // underflow mid-method
		'{8'hff, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},   // dropped
		'{8'hc4, 1'b1, 1'b0, 32'd0, jbsm_pkg::END_CODE},   // wide, dropped last
		'{8'h0f, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},   // double 1.0 pattern
		'{jbsm_pkg::OP_ISTORE0, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_ILOAD0, 1'b0, 1'b0, 32'd0, jbsm_pkg::END_CODE},
		'{jbsm_pkg::OP_IRETURN, 1'b1, 1'b0, 32'd0, jbsm_pkg::END_CODE}
	};

	// ---------------- receiver ----------------
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(negedge clk);
				hold_off = 1'b0;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(0, 16);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// ---------------- checker ----------------
	always @(posedge clk) begin
		jbsm_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (endings_q.size() == 0) begin
				$display("%0t: ending expected none actual rv=%0d kind=%0d", $time,
					out_item.return_value, out_item.end_kind);
				errors++;
			end else begin
				e = endings_q.pop_front();
				n_checked++;
				if (out_item.end_kind == jbsm_pkg::END_FAULT) n_faults++;
				if (out_item.end_kind == jbsm_pkg::END_INT) n_iret++;
				if (out_item.return_value !== e.return_value) begin
					$display("%0t: return_value expected %0d actual %0d", $time,
						$signed(e.return_value), out_item.return_value);
					errors++;
				end
				if (out_item.end_kind !== e.end_kind) begin
					$display("%0t: end_kind expected %0d actual %0d", $time,
						e.end_kind, out_item.end_kind);
					errors++;
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		int sent;
		int n;
		jbsm_pkg::out_item_t typed;
		errors = 0;
		n_checked = 0;
		n_faults = 0;
		n_iret = 0;
		cycles = 0;
		hold_off = 1'b0;
		hold_len = 0;
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		fresh_frame();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: typed endings cross-check the interpreter
		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].b, dir_tab[i].last);
			if (dir_tab[i].has_exp) begin
				typed.return_value = dir_tab[i].rv;
				typed.end_kind = dir_tab[i].kind;
				if (endings_q.size() == 0) begin
					$display("%0t: table row %0d expected rv=%0d kind=%0d actual none",
						$time, i, $signed(dir_tab[i].rv), dir_tab[i].kind);
					errors++;
				end else if (endings_q[$] != typed) begin
					$display("%0t: table row %0d expected rv=%0d kind=%0d actual rv=%0d kind=%0d",
						$time, i, $signed(dir_tab[i].rv), dir_tab[i].kind,
						endings_q[$].return_value, endings_q[$].end_kind);
					errors++;
				end
			end
		end

		// overflow: 17 pushes, then idiv by zero, then MIN / -1
		for (int i = 0; i <= DEPTH; i++) send_byte(8'h08, i == DEPTH);
		send_byte(jbsm_pkg::OP_SIPUSH, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(jbsm_pkg::OP_SIPUSH, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(jbsm_pkg::OP_IMUL, 1'b0); send_byte(jbsm_pkg::OP_ISTORE0 + 8'd3, 1'b0);
		send_byte(8'h05, 1'b0); send_byte(8'h01, 1'b0); send_byte(jbsm_pkg::OP_IDIV, 1'b0);
		send_byte(jbsm_pkg::OP_IRETURN, 1'b1);
		// -32768 * -32768 * 2 wraps to MIN, then divide by -1
		send_byte(jbsm_pkg::OP_SIPUSH, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(jbsm_pkg::OP_SIPUSH, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
		send_byte(jbsm_pkg::OP_IMUL, 1'b0); send_byte(8'h05, 1'b0);
		send_byte(jbsm_pkg::OP_IMUL, 1'b0); send_byte(8'h02, 1'b0);
		send_byte(jbsm_pkg::OP_IDIV, 1'b0); send_byte(jbsm_pkg::OP_IRETURN, 1'b1);
		for (int i = 0; i < 16; i++) send_byte(8'h08, 1'b0);
		send_byte(jbsm_pkg::OP_IMUL, 1'b0); send_byte(jbsm_pkg::OP_IRETURN, 1'b1);
		wait_drained();

		// receiver stalls long while methods keep coming
		hold_len = 400;
		hold_off = 1'b1;
		for (int i = 0; i < 12; i++) send_method(2);
		wait_drained();

		sent = 0;
		while (sent < N_RANDOM) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
			send_method(n);
			sent += n;
		end
		wait_drained();

		$display("Checked %0d method endings (%0d int returns, %0d stack faults).",
			n_checked, n_iret, n_faults);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
